// File: rtl/cbe_pkg.sv
// cbe_pkg: shared types, constants and fixed-point helpers for the ease curve block
// no dependencies; used by every module in rtl/

package cbe_pkg;

   // fixed-point formats
   localparam int IO_BITS      = 16;
   localparam int IO_W         = IO_BITS + 1;
   localparam int FRAC_BITS    = 16;
   localparam int FX_W         = FRAC_BITS + 1;
   localparam int BISECT_STEPS = 16;
   localparam int UP_SH        = (FRAC_BITS > IO_BITS) ? (FRAC_BITS - IO_BITS) : 0;
   localparam int DN_SH        = (FRAC_BITS < IO_BITS) ? (IO_BITS - FRAC_BITS) : 0;
   localparam int ROUND_HALF   = (1 << UP_SH) >> 1;

   localparam int COEF_BITS = 24;
   localparam int COEF_W    = COEF_BITS + 2;
   localparam int PROD_W    = 2 * FX_W;
   localparam int CP_W      = FX_W + COEF_W;
   localparam int CM_W      = FX_W + 2;
   localparam int SUM_W     = FX_W + 3;
   localparam int WIDE_W    = 32;

   // pipeline depths
   localparam int POLY_LAT = 3;

   localparam logic [IO_W-1:0] IO_ONE  = {1'b1, {IO_BITS{1'b0}}};
   localparam logic [FX_W-1:0] FX_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FX_W-1:0] FX_HALF = FX_ONE >> 1;

   // q24 curve coefficients: 3*0.25, 3*0.1 (rounded), 3*1.0
   localparam logic [COEF_W-1:0] CX_A = COEF_W'(12582912);
   localparam logic [COEF_W-1:0] CX_B = COEF_W'(12582912);
   localparam logic [COEF_W-1:0] CY_A = COEF_W'(5033165);
   localparam logic [COEF_W-1:0] CY_B = COEF_W'(50331648);
   localparam logic [CP_W-1:0]   COEF_HALF = CP_W'(1) << (COEF_BITS - 1);

   typedef enum logic [1:0] {
      SPEC_NONE,
      SPEC_ZERO,
      SPEC_ONE
   } spec_type;

   // one request as it travels down the bisection row
   typedef struct packed {
      logic            valid;
      spec_type        spec;
      logic [FX_W-1:0] tq;
      logic [FX_W-1:0] lo;
      logic [FX_W-1:0] hi;
      logic [FX_W-1:0] u;
   } lane_type;

   typedef struct packed {
      logic     valid;
      spec_type spec;
   } tail_type;

   // qF x qF, rounded to qF
   function automatic logic [FX_W-1:0] fx_mul(input logic [FX_W-1:0] a,
                                              input logic [FX_W-1:0] b);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(a) * PROD_W'(b) + PROD_W'(FX_HALF);
      return prod[FRAC_BITS +: FX_W];
   endfunction

   // qF x q24 coefficient, rounded to qF
   function automatic logic [CM_W-1:0] coef_mul(input logic [FX_W-1:0]   p,
                                                input logic [COEF_W-1:0] c);
      logic [CP_W-1:0] prod;
      prod = CP_W'(p) * CP_W'(c) + COEF_HALF;
      return prod[COEF_BITS +: CM_W];
   endfunction

endpackage

// File: rtl/cbe_poly.sv
// cbe_poly: three-stage pipelined bezier polynomial for one parameter value
// depends on cbe_pkg (fx_mul, coef_mul, widths)

module cbe_poly (
   input  logic                        clock,
   input  logic                        en,
   input  logic [cbe_pkg::FX_W-1:0]    mid,
   input  logic [cbe_pkg::COEF_W-1:0]  ca,
   input  logic [cbe_pkg::COEF_W-1:0]  cb,
   output logic [cbe_pkg::FX_W-1:0]    u_dly,
   output logic [cbe_pkg::SUM_W-1:0]   sum
);

   logic [cbe_pkg::FX_W-1:0] v;
   logic [cbe_pkg::FX_W-1:0] s1_u_ff, s1_v_ff, s1_uv_ff, s1_uu_ff;
   logic [cbe_pkg::FX_W-1:0] s2_u_ff, s2_p1_ff, s2_p2_ff, s2_p3_ff;
   logic [cbe_pkg::FX_W-1:0] s3_u_ff, s3_p3_ff;
   logic [cbe_pkg::CM_W-1:0] s3_c1_ff, s3_c2_ff;

   assign v = cbe_pkg::FX_ONE - mid;

   always_ff @(posedge clock) begin
      if (en) begin
         // u*v and u*u
         s1_u_ff  <= mid;
         s1_v_ff  <= v;
         s1_uv_ff <= cbe_pkg::fx_mul(mid, v);
         s1_uu_ff <= cbe_pkg::fx_mul(mid, mid);
         // cubic terms
         s2_u_ff  <= s1_u_ff;
         s2_p1_ff <= cbe_pkg::fx_mul(s1_uv_ff, s1_v_ff);
         s2_p2_ff <= cbe_pkg::fx_mul(s1_uv_ff, s1_u_ff);
         s2_p3_ff <= cbe_pkg::fx_mul(s1_uu_ff, s1_u_ff);
         // coefficient scaling
         s3_u_ff  <= s2_u_ff;
         s3_c1_ff <= cbe_pkg::coef_mul(s2_p1_ff, ca);
         s3_c2_ff <= cbe_pkg::coef_mul(s2_p2_ff, cb);
         s3_p3_ff <= s2_p3_ff;
      end
   end

   assign u_dly = s3_u_ff;
   assign sum   = cbe_pkg::SUM_W'(s3_c1_ff) + cbe_pkg::SUM_W'(s3_c2_ff)
                + cbe_pkg::SUM_W'(s3_p3_ff);

endmodule

// File: rtl/cbe_cell.sv
// cbe_cell: one bisection step, midpoint -> x(u) -> compare -> narrowed bounds
// depends on cbe_pkg and cbe_poly

module cbe_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  cbe_pkg::lane_type up_lane,
   output cbe_pkg::lane_type dn_lane
);

   logic [cbe_pkg::FX_W:0]    bound_sum;
   logic [cbe_pkg::FX_W-1:0]  mid;
   logic [cbe_pkg::FX_W-1:0]  poly_u;
   logic [cbe_pkg::SUM_W-1:0] poly_sum;
   cbe_pkg::lane_type         side_ff [cbe_pkg::POLY_LAT];
   cbe_pkg::lane_type         dn_in;
   cbe_pkg::lane_type         dn_ff;

   // truncated midpoint of the current bracket
   assign bound_sum = {1'b0, up_lane.lo} + {1'b0, up_lane.hi};
   assign mid       = bound_sum[cbe_pkg::FX_W:1];

   cbe_poly u_poly (
      .clock (clock),
      .en    (en),
      .mid   (mid),
      .ca    (cbe_pkg::CX_A),
      .cb    (cbe_pkg::CX_B),
      .u_dly (poly_u),
      .sum   (poly_sum)
   );

   always_comb begin
      dn_in   = side_ff[cbe_pkg::POLY_LAT-1];
      dn_in.u = poly_u;
      if (poly_sum < cbe_pkg::SUM_W'(dn_in.tq)) begin
         dn_in.lo = poly_u;
      end else begin
         dn_in.hi = poly_u;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbe_pkg::POLY_LAT; i++) begin
            side_ff[i].valid <= 1'b0;
         end
         dn_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff[0] <= up_lane;
         for (int i = 1; i < cbe_pkg::POLY_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         dn_ff <= dn_in;
      end
   end

   assign dn_lane = dn_ff;

endmodule

// File: rtl/cbe_out_buf.sv
// cbe_out_buf: output register with one skid entry for the response channel
// depends on cbe_pkg (IO_W)

module cbe_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [cbe_pkg::IO_W-1:0] in_value,
   input  logic                     out_ready,
   output logic                     out_valid,
   output logic [cbe_pkg::IO_W-1:0] out_value,
   output logic                     full
);

   logic                     main_valid_ff, main_valid_in;
   logic                     skid_valid_ff, skid_valid_in;
   logic [cbe_pkg::IO_W-1:0] main_ff, main_in;
   logic [cbe_pkg::IO_W-1:0] skid_ff, skid_in;
   logic                     push, pop;

   assign push = in_valid && !skid_valid_ff;
   assign pop  = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_value;
            main_valid_in = push;
         end
      end else if (push) begin
         // response held, park the new one
         skid_in       = in_value;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_value = main_ff;
   assign full      = skid_valid_ff;

endmodule

// File: rtl/cubic_bezier_ease_curve.sv
// cubic_bezier_ease_curve: top level of the css "ease" timing curve evaluator
// depends on cbe_pkg, cbe_poly, cbe_cell and cbe_out_buf

// Maps a q16 time sample to the eased progress of cubic-bezier(0.25, 0.1, 0.25, 1),
// also in unsigned q16 (65536 = 1.0). A time of zero returns zero and any time at
// or past 65536 returns 65536. Otherwise a row of 16 identical bisection cells
// searches for the curve parameter whose x equals the time, one halving per cell,
// and the y polynomial is evaluated at the last midpoint. The block takes one
// request per clock and keeps streaming as long as responses are taken. Each cell
// is four register stages deep (three for the pipelined x polynomial, one for the
// compare and bound update), so an unstalled request passes the input register,
// which loads at the accepting edge, then the cell row, the y polynomial stages
// and the output register before rsp_valid. The whole pipeline holds while the
// output skid entry is occupied; a held response does not stop acceptance until
// that entry fills.

module cubic_bezier_ease_curve (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [cbe_pkg::IO_W-1:0] req_time_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [cbe_pkg::IO_W-1:0] rsp_eased_out
);

   // global pipeline advance, from a register only
   logic pipe_en;
   logic skid_full;

   cbe_pkg::lane_type head_in, head_ff;
   cbe_pkg::lane_type chain_lane [cbe_pkg::BISECT_STEPS+1];

   logic [cbe_pkg::WIDE_W-1:0] tq_wide;

   // y polynomial and its sideband
   logic [cbe_pkg::FX_W-1:0]  y_u;
   logic [cbe_pkg::SUM_W-1:0] y_sum;
   cbe_pkg::tail_type         tail_ff [cbe_pkg::POLY_LAT];
   cbe_pkg::tail_type         tail_last;

   logic [cbe_pkg::WIDE_W-1:0] y_wide;
   logic [cbe_pkg::IO_W-1:0]   y_sat;
   logic [cbe_pkg::IO_W-1:0]   result;

   assign pipe_en   = !skid_full;
   assign req_ready = pipe_en;

   // input stage: classify the time and open the bracket at [0, 1]
   assign tq_wide = (cbe_pkg::WIDE_W'(req_time_in) << cbe_pkg::UP_SH) >> cbe_pkg::DN_SH;

   always_comb begin
      head_in.valid = req_valid;
      head_in.tq    = tq_wide[cbe_pkg::FX_W-1:0];
      head_in.lo    = '0;
      head_in.hi    = cbe_pkg::FX_ONE;
      head_in.u     = '0;
      if (req_time_in[cbe_pkg::IO_BITS]) begin
         head_in.spec = cbe_pkg::SPEC_ONE;
      end else if (req_time_in == '0) begin
         head_in.spec = cbe_pkg::SPEC_ZERO;
      end else begin
         head_in.spec = cbe_pkg::SPEC_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (pipe_en) begin
         head_ff <= head_in;
      end
   end

   assign chain_lane[0] = head_ff;

   // row of bisection cells, each halves the bracket once
   for (genvar g = 0; g < cbe_pkg::BISECT_STEPS; g++) begin : g_cell
      cbe_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (pipe_en),
         .up_lane (chain_lane[g]),
         .dn_lane (chain_lane[g+1])
      );
   end

   // y at the last midpoint
   cbe_poly u_ypoly (
      .clock (clock),
      .en    (pipe_en),
      .mid   (chain_lane[cbe_pkg::BISECT_STEPS].u),
      .ca    (cbe_pkg::CY_A),
      .cb    (cbe_pkg::CY_B),
      .u_dly (y_u),
      .sum   (y_sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbe_pkg::POLY_LAT; i++) begin
            tail_ff[i].valid <= 1'b0;
         end
      end else if (pipe_en) begin
         tail_ff[0].valid <= chain_lane[cbe_pkg::BISECT_STEPS].valid;
         tail_ff[0].spec  <= chain_lane[cbe_pkg::BISECT_STEPS].spec;
         for (int i = 1; i < cbe_pkg::POLY_LAT; i++) begin
            tail_ff[i] <= tail_ff[i-1];
         end
      end
   end

   assign tail_last = tail_ff[cbe_pkg::POLY_LAT-1];

   // qF back to q16, then clip at one
   assign y_wide = ((cbe_pkg::WIDE_W'(y_sum) + cbe_pkg::WIDE_W'(cbe_pkg::ROUND_HALF))
                    >> cbe_pkg::UP_SH) << cbe_pkg::DN_SH;
   assign y_sat  = (y_wide > cbe_pkg::WIDE_W'(cbe_pkg::IO_ONE)) ? cbe_pkg::IO_ONE
                 : y_wide[cbe_pkg::IO_W-1:0];

   always_comb begin
      unique case (tail_last.spec)
         cbe_pkg::SPEC_ZERO: result = '0;
         cbe_pkg::SPEC_ONE:  result = cbe_pkg::IO_ONE;
         default:            result = y_sat;
      endcase
   end

   cbe_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tail_last.valid && pipe_en),
      .in_value  (result),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_value (rsp_eased_out),
      .full      (skid_full)
   );

   // backpressure only ever comes from a held response
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no response pending");

   // a stall freezes the end of the cell row
   assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(chain_lane[cbe_pkg::BISECT_STEPS]))
      else $error("cell row moved during stall");

   // the bracket never inverts or leaves [0, 1]
   assert property (@(posedge clock) disable iff (reset)
      chain_lane[cbe_pkg::BISECT_STEPS].valid |->
         (chain_lane[cbe_pkg::BISECT_STEPS].lo <= chain_lane[cbe_pkg::BISECT_STEPS].hi)
         && (chain_lane[cbe_pkg::BISECT_STEPS].hi <= cbe_pkg::FX_ONE))
      else $error("bisection bracket out of order");

endmodule

// File: tb/sv/cubic_bezier_ease_curve_tb.sv
// cubic_bezier_ease_curve_tb: self-checking bench for the css "ease" curve evaluator
// drives q16 time requests with random bursts and stalls, predicts every eased value
// depends on cbe_pkg and cubic_bezier_ease_curve
`timescale 1ns / 100ps

module cubic_bezier_ease_curve_tb;

   typedef logic [cbe_pkg::IO_W-1:0] q16_type;

   // one pending time request; drain_first makes the sender wait for an empty pipe
   typedef struct {
      q16_type t;
      bit      drain_first;
   } time_req_type;

   typedef enum {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC
   } stall_mode_type;

   // curve math in the block's fraction width, held in 64 bits
   localparam int              F        = cbe_pkg::FRAC_BITS;
   localparam longint unsigned Q_ONE    = 64'd1 << F;
   localparam int              CQ_BITS  = 24;
   localparam longint unsigned CQ_HALF  = 64'd1 << (CQ_BITS - 1);
   // q24 weights: x uses 3*0.25 on both inner terms, y uses 3*0.1 and 3*1.0
   localparam longint unsigned X_W1     = 64'd12582912;
   localparam longint unsigned X_W2     = 64'd12582912;
   localparam longint unsigned Y_W1     = 64'd5033165;
   localparam longint unsigned Y_W2     = 64'd50331648;
   localparam q16_type         Q16_ONE  = q16_type'(1) << cbe_pkg::IO_BITS;

   localparam int DIRECTED_REQS = 22;
   localparam int RANDOM_REQS   = 1330;
   localparam int HOLD_AFTER    = 450;   // responses held off once this many requests went in
   localparam int HOLD_CYCLES   = 600;
   localparam int TAIL_CYCLES   = 100;
   localparam int CYCLE_LIMIT   = 200000;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   q16_type req_time_in = '0;
   logic    rsp_ready   = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   q16_type rsp_eased_out;

   cubic_bezier_ease_curve dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_time_in   (req_time_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_eased_out (rsp_eased_out)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // qF x qF with round half up
   function automatic longint unsigned q_mul(input longint unsigned a,
                                             input longint unsigned b);
      return (a * b + (Q_ONE >> 1)) >> F;
   endfunction

   // qF term times a q24 weight, rounded back to qF
   function automatic longint unsigned weigh(input longint unsigned p,
                                             input longint unsigned w);
      return (p * w + CQ_HALF) >> CQ_BITS;
   endfunction

   // 3 v^2 u w1 + 3 v u^2 w2 + u^3 with the factor 3 folded into the weights
   function automatic longint unsigned bezier_at(input longint unsigned u,
                                                 input longint unsigned w1,
                                                 input longint unsigned w2);
      longint unsigned v;
      longint unsigned uv;
      v  = Q_ONE - u;
      uv = q_mul(u, v);
      return weigh(q_mul(uv, v), w1) + weigh(q_mul(uv, u), w2) + q_mul(q_mul(u, u), u);
   endfunction

   function automatic q16_type eased_from_time(input q16_type t);
      longint unsigned tq;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned u;
      longint unsigned y;
      // clamps at both ends bypass the search
      if (t == '0)
         return '0;
      if (t >= Q16_ONE)
         return Q16_ONE;
      tq = (longint'(t) << cbe_pkg::UP_SH) >> cbe_pkg::DN_SH;
      lo = 0;
      hi = Q_ONE;
      u  = tq;
      // fixed-length bisection, the last midpoint wins even if it stalls
      for (int i = 0; i < cbe_pkg::BISECT_STEPS; i++) begin
         u = (lo + hi) >> 1;
         if (bezier_at(u, X_W1, X_W2) < tq)
            lo = u;
         else
            hi = u;
      end
      y = bezier_at(u, Y_W1, Y_W2);
      y = ((y + ((64'd1 << cbe_pkg::UP_SH) >> 1)) >> cbe_pkg::UP_SH) << cbe_pkg::DN_SH;
      if (y > Q16_ONE)
         y = Q16_ONE;
      return q16_type'(y);
   endfunction

   // ---------------------------------------------------------------------------
   // shared bench state
   // ---------------------------------------------------------------------------
   time_req_type time_queue[$];       // requests not yet offered
   q16_type      expected_eased[$];   // predictions waiting for their response
   int        total_reqs      = 0;
   int        accepted_reqs   = 0;
   int        checked_rsps    = 0;
   int        eased_errors    = 0;
   int        zero_reqs       = 0;
   int        full_reqs       = 0;
   int        stall_run       = 0;
   int        longest_stall   = 0;
   int        cycle_count     = 0;
   bit        req_taken       = 1'b0;

   // ---------------------------------------------------------------------------
   // driver: bursts of random length, random gaps between them
   // ---------------------------------------------------------------------------
   int           burst_left = 0;
   int           gap_left   = 0;
   time_req_type next_req;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // offer stands until it is taken
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (time_queue.size() == 0 ||
                   (time_queue[0].drain_first && expected_eased.size() != 0)) begin
         // nothing left, or pausing until every response is back
         req_valid <= 1'b0;
      end else begin
         next_req = time_queue.pop_front();
         req_valid   <= 1'b1;
         req_time_in <= next_req.t;
         if (burst_left == 0)
            burst_left = $urandom_range(1, 40);
         burst_left--;
         if (burst_left == 0)
            // roughly one burst in four runs straight into the next
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
   end

   // ---------------------------------------------------------------------------
   // receiver: switches between stall patterns, plus one long hold-off so the
   // pipe fills and the block has to drop req_ready
   // ---------------------------------------------------------------------------
   stall_mode_type stall_mode   = STALL_NONE;
   int             mode_left    = 0;
   int             hold_left    = 0;
   bit             hold_done    = 1'b0;
   int             period_phase = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && accepted_reqs >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 2));
               mode_left  = $urandom_range(50, 250);
            end
            mode_left--;
            case (stall_mode)
               STALL_NONE: begin
                  rsp_ready <= 1'b1;
               end
               STALL_RANDOM: begin
                  rsp_ready <= ($urandom_range(0, 9) < 7);
               end
               default: begin
                  // ready only on phase zero of the period counter
                  rsp_ready <= (period_phase == 0);
                  period_phase = (period_phase + 1) % 3;
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: predicts on every accepted request, checks every accepted response
   // ---------------------------------------------------------------------------
   q16_type want;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d of %0d requests checked",
                  checked_rsps, total_reqs);
         $display("cubic_bezier_ease_curve_tb: FAIL");
         $finish;
      end else if (!reset) begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            expected_eased.push_back(eased_from_time(req_time_in));
            accepted_reqs++;
            if (req_time_in == '0)
               zero_reqs++;
            if (req_time_in >= Q16_ONE)
               full_reqs++;
         end
         // how long the block held a request off
         if (req_valid && !req_ready) begin
            stall_run++;
            if (stall_run > longest_stall)
               longest_stall = stall_run;
         end else begin
            stall_run = 0;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_eased.size() == 0) begin
               $error("eased_out: response %0d with no request outstanding",
                      rsp_eased_out);
               eased_errors++;
            end else begin
               want = expected_eased.pop_front();
               checked_rsps++;
               if (rsp_eased_out !== want) begin
                  $error("eased_out: expected %0d, actual %0d", want, rsp_eased_out);
                  eased_errors++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------
   q16_type directed_times[DIRECTED_REQS] = '{
      17'd0, 17'd1, 17'd2, 17'd3, 17'd255, 17'd256, 17'd4096, 17'd16384,
      17'd21845, 17'd32767, 17'd32768, 17'd32769, 17'd43690, 17'd49152,
      17'd65280, 17'd65534, 17'd65535, 17'd65536, 17'd65537, 17'd98304,
      17'd131071, 17'd0
   };

   initial begin
      int           pick;
      time_req_type item;

      // edges and midpoints first, then the ragged ends of the range
      foreach (directed_times[i]) begin
         item.t           = directed_times[i];
         item.drain_first = 1'b0;
         time_queue.push_back(item);
      end
      for (int i = 0; i < RANDOM_REQS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4)
            item.t = '0;
         else if (pick < 8)
            item.t = Q16_ONE;
         else if (pick < 16)
            item.t = q16_type'($urandom_range(32'h10001, 32'h1FFFF));   // past one, clamps
         else if (pick < 26)
            item.t = q16_type'($urandom_range(1, 255));          // shallow start of curve
         else if (pick < 30)
            item.t = q16_type'($urandom_range(32'hFF00, 32'hFFFF));     // just under one
         else
            item.t = q16_type'($urandom_range(1, 32'hFFFF));
         // sender drains the pipe after the directed part and now and then later
         item.drain_first = (i % 300 == 0);
         time_queue.push_back(item);
      end
      total_reqs = time_queue.size();

      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // sampled at the falling edge so every rising-edge update has landed
      while (accepted_reqs != total_reqs || checked_rsps != accepted_reqs)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (expected_eased.size() != 0) begin
         $error("eased_out: %0d predictions never answered", expected_eased.size());
         eased_errors++;
      end

      $display("run covered %0d time requests (%0d at zero, %0d at or past one)",
               checked_rsps, zero_reqs, full_reqs);
      $display("longest input back-pressure %0d cycles, %0d errors", longest_stall,
               eased_errors);
      if (eased_errors == 0)
         $display("cubic_bezier_ease_curve_tb: PASS");
      else
         $display("cubic_bezier_ease_curve_tb: FAIL");
      $finish;
   end

endmodule
